// ===== rtl/core/swcc_pkg.sv =====
// Package for the sensor word CRC checker.
// Holds the CRC-8 constants, the status codes, the result struct and the CRC fold function.
// It depends on nothing else.
package swcc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned POS_W = 3;

	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
	localparam logic [BYTE_W-1:0] CRC_TOP_BIT = 8'h80;
	localparam logic [BYTE_W-1:0] POLY_RESET = 8'h31;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FIRST_BAD = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SECOND_BAD = 2'd2;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0] first_word;
		logic [WORD_W-1:0] second_word;
	} result_t;

	// Folds one byte into an MSB-first CRC-8 with no reflection.
	function automatic logic [BYTE_W-1:0] crc_fold(
		input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data,
		input logic [BYTE_W-1:0] poly
	);
		logic [BYTE_W-1:0] r;
		r = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if ((r & CRC_TOP_BIT) != '0) begin
				r = {r[BYTE_W-2:0], 1'b0} ^ poly;
			end else begin
				r = {r[BYTE_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/sensor_word_crc_checker.sv =====
// Top level of the sensor word CRC checker: input register, polynomial
// register, result register and the stall logic between them.
// It depends on swcc_pkg and swcc_frame.
//
// Usage: received bytes arrive one request at a time on in_valid / in_stall /
// rx_byte, six to a frame: first word high and low byte, its CRC-8, second
// word high and low byte, its CRC-8. One byte is taken every cycle while
// in_stall is low. A byte is registered at acceptance and folded into the
// frame when it leaves that register. After the sixth byte is folded, one
// result request (status, first_word, second_word) is presented on
// out_valid / out_stall / status / first_word / second_word from the result
// register, showing the stored good words after this frame's update.
// The polynomial is written through cfg_valid / cfg_ready / crc_polynomial,
// which is always ready. The user must write it only while the block is idle;
// the block does not enforce this. Reset clears the frame position, sets the
// CRC to 0xFF, the polynomial to 0x31 and the stored words to zero, and drops
// any held byte or result. When the receiver stalls, the result holds; bytes
// keep flowing until the sixth byte of the next frame would need the result
// register, and then in_stall rises until the result is taken.
module sensor_word_crc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [swcc_pkg::BYTE_W-1:0]        rx_byte,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [swcc_pkg::BYTE_W-1:0]        crc_polynomial,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [swcc_pkg::STATUS_W-1:0]      status,
	output logic [swcc_pkg::WORD_W-1:0]        first_word,
	output logic [swcc_pkg::WORD_W-1:0]        second_word
);

	logic                        valid_s1;
	logic [swcc_pkg::BYTE_W-1:0] byte_s1;
	logic [swcc_pkg::BYTE_W-1:0] poly_q;
	logic                        out_valid_q;
	swcc_pkg::result_t           out_q;

	logic              frame_end;
	swcc_pkg::result_t result;
	logic              out_free;
	logic              advance;
	logic              accept;

	assign out_free = !out_valid_q || !out_stall;
	assign advance = valid_s1 && (!frame_end || out_free);
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= swcc_pkg::POLY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			poly_q <= crc_polynomial;
		end
	end

	swcc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (advance),
		.byte_data (byte_s1),
		.poly      (poly_q),
		.frame_end (frame_end),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_end) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign first_word = out_q.first_word;
	assign second_word = out_q.second_word;

endmodule

// ===== rtl/core/swcc_frame.sv =====
// Frame tracker of the sensor word CRC checker: byte position, running CRC,
// word assembly, stored good words and the end-of-frame result.
// It depends on swcc_pkg.
module swcc_frame (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             byte_en,
	input  logic [swcc_pkg::BYTE_W-1:0]      byte_data,
	input  logic [swcc_pkg::BYTE_W-1:0]      poly,
	output logic                             frame_end,
	output swcc_pkg::result_t                result
);

	localparam logic [swcc_pkg::POS_W-1:0] POS_W1_HI = 3'd0;
	localparam logic [swcc_pkg::POS_W-1:0] POS_W1_LO = 3'd1;
	localparam logic [swcc_pkg::POS_W-1:0] POS_CRC1 = 3'd2;
	localparam logic [swcc_pkg::POS_W-1:0] POS_W2_HI = 3'd3;
	localparam logic [swcc_pkg::POS_W-1:0] POS_W2_LO = 3'd4;
	localparam logic [swcc_pkg::POS_W-1:0] POS_CRC2 = 3'd5;

	logic [swcc_pkg::POS_W-1:0]  pos_q;
	logic [swcc_pkg::BYTE_W-1:0] crc_q;
	logic [swcc_pkg::WORD_W-1:0] word_q;
	logic [swcc_pkg::WORD_W-1:0] pending_q;
	logic                        first_bad_q;
	logic [swcc_pkg::WORD_W-1:0] good_first_q;
	logic [swcc_pkg::WORD_W-1:0] good_second_q;

	logic [swcc_pkg::BYTE_W-1:0] crc_next;
	logic                        second_bad;
	logic [swcc_pkg::STATUS_W-1:0] status;

	assign crc_next = swcc_pkg::crc_fold(crc_q, byte_data, poly);
	assign frame_end = (pos_q == POS_CRC2);
	assign second_bad = (crc_q != byte_data);

	always_comb begin
		if (first_bad_q) begin
			status = swcc_pkg::STATUS_FIRST_BAD;
		end else if (second_bad) begin
			status = swcc_pkg::STATUS_SECOND_BAD;
		end else begin
			status = swcc_pkg::STATUS_OK;
		end
	end

	always_comb begin
		result.status = status;
		if (status == swcc_pkg::STATUS_OK) begin
			result.first_word = pending_q;
			result.second_word = word_q;
		end else begin
			result.first_word = good_first_q;
			result.second_word = good_second_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_W1_HI;
			crc_q <= swcc_pkg::CRC_INIT;
			word_q <= '0;
			pending_q <= '0;
			first_bad_q <= 1'b0;
			good_first_q <= '0;
			good_second_q <= '0;
		end else if (byte_en) begin
			case (pos_q)
				POS_W1_LO, POS_W2_LO: begin
					crc_q <= crc_next;
					word_q <= {word_q[swcc_pkg::WORD_W-1:swcc_pkg::BYTE_W], byte_data};
					pos_q <= pos_q + 3'd1;
				end
				POS_CRC1: begin
					first_bad_q <= (crc_q != byte_data);
					pending_q <= word_q;
					crc_q <= swcc_pkg::CRC_INIT;
					pos_q <= POS_W2_HI;
				end
				POS_W2_HI: begin
					crc_q <= crc_next;
					word_q <= {byte_data, {swcc_pkg::BYTE_W{1'b0}}};
					pos_q <= POS_W2_LO;
				end
				POS_CRC2: begin
					if (status == swcc_pkg::STATUS_OK) begin
						good_first_q <= pending_q;
						good_second_q <= word_q;
					end
					crc_q <= swcc_pkg::CRC_INIT;
					pos_q <= POS_W1_HI;
				end
				default: begin
					// The first word's high byte, and any unused position restarting a frame.
					crc_q <= crc_next;
					word_q <= {byte_data, {swcc_pkg::BYTE_W{1'b0}}};
					pos_q <= POS_W1_LO;
				end
			endcase
		end
	end

endmodule
